@@ design/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB/HSV color converter: component and
// hue widths, hue sector layout, divider pipeline sizing and payload structs.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CMP_BITS     = 8;
   localparam int HUE_BITS     = 11;
   localparam int FRAC_BITS    = 8;
   localparam int SEC_BITS     = HUE_BITS - FRAC_BITS;
   localparam int SECTOR_STEPS = 1 << FRAC_BITS;

   localparam logic [CMP_BITS-1:0] CMP_MAX = '1;

   localparam logic [HUE_BITS-1:0] TURN_STEPS = HUE_BITS'(6 * SECTOR_STEPS);
   localparam logic [HUE_BITS-1:0] GREEN_BASE = HUE_BITS'(2 * SECTOR_STEPS);
   localparam logic [HUE_BITS-1:0] BLUE_BASE  = HUE_BITS'(4 * SECTOR_STEPS);

   localparam int HUE_QBITS  = FRAC_BITS + 1;
   localparam int DIV_BPS    = 2;
   localparam int DIV_QMAX   = (HUE_QBITS > CMP_BITS) ? HUE_QBITS : CMP_BITS;
   localparam int DIV_STAGES = (DIV_QMAX + DIV_BPS - 1) / DIV_BPS;

   localparam int HSV_STAGES = 4;
   localparam int PIPE_DEPTH = DIV_STAGES + 2;
   localparam int HSV_DELAY  = PIPE_DEPTH - HSV_STAGES;

   typedef logic [CMP_BITS-1:0] cmp_type;
   typedef logic [HUE_BITS-1:0] hue_type;

   typedef enum logic {
      KIND_RGB_TO_HSV,
      KIND_HSV_TO_RGB
   } kind_type;

   typedef enum logic [1:0] {
      HUE_RED_UP,
      HUE_RED_DOWN,
      HUE_GREEN,
      HUE_BLUE
   } hue_case_type;

   typedef enum logic [SEC_BITS-1:0] {
      SEC_RED,
      SEC_YELLOW,
      SEC_GREEN,
      SEC_CYAN,
      SEC_BLUE,
      SEC_MAGENTA
   } sector_type;

   typedef struct packed {
      kind_type kind;
      cmp_type  red_in;
      cmp_type  green_in;
      cmp_type  blue_in;
      hue_type  hue_in;
      cmp_type  sat_in;
      cmp_type  value_in;
   } req_type;

   typedef struct packed {
      cmp_type red_out;
      cmp_type green_out;
      cmp_type blue_out;
      hue_type hue_out;
      cmp_type sat_out;
      cmp_type value_out;
   } rsp_type;

endpackage

@@ design/rhc_divider.sv @@
// ----------------------------------------------------------------------------
// rhc_divider
// Pipelined restoring divider: BPS quotient bits per stage, each stage
// registered, a new division may enter every cycle.
// ----------------------------------------------------------------------------
module rhc_divider
   import rhc_pkg::*;
#(
   parameter int NW  = 2 * CMP_BITS,
   parameter int DW  = CMP_BITS,
   parameter int QB  = CMP_BITS,
   parameter int NS  = DIV_STAGES,
   parameter int BPS = DIV_BPS
) (
   input  logic          clock,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [QB-1:0] quotient
);

   localparam int QP = NS * BPS;
   localparam int CW = (NW > DW + QP) ? NW : DW + QP;

   logic [CW-1:0] rem_src [NS];
   logic [CW-1:0] rem_in  [NS];
   logic [CW-1:0] rem_ff  [NS-1];
   logic [QP-1:0] quo_src [NS];
   logic [QP-1:0] quo_in  [NS];
   logic [QP-1:0] quo_ff  [NS];
   logic [DW-1:0] den_src [NS];
   logic [DW-1:0] den_ff  [NS-1];
   logic [CW-1:0] trial;

   always_comb begin
      rem_src[0] = CW'(dividend);
      quo_src[0] = '0;
      den_src[0] = divisor;
      for (int j = 1; j < NS; j++) begin
         rem_src[j] = rem_ff[j-1];
         quo_src[j] = quo_ff[j-1];
         den_src[j] = den_ff[j-1];
      end
      trial = '0;
      for (int j = 0; j < NS; j++) begin
         rem_in[j] = rem_src[j];
         quo_in[j] = quo_src[j];
         for (int b = 0; b < BPS; b++) begin
            trial = CW'(den_src[j]) << (QP - 1 - j * BPS - b);
            if (rem_in[j] >= trial) begin
               rem_in[j] = rem_in[j] - trial;
               quo_in[j][QP - 1 - j * BPS - b] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NS - 1; j++) begin
         rem_ff[j] <= rem_in[j];
         den_ff[j] <= den_src[j];
      end
      for (int j = 0; j < NS; j++) begin
         quo_ff[j] <= quo_in[j];
      end
   end

   assign quotient = quo_ff[NS-1][QB-1:0];

endmodule

@@ design/rhc_rgb_path.sv @@
// ----------------------------------------------------------------------------
// rhc_rgb_path
// RGB to HSV: max/min front stage, pipelined hue and saturation dividers,
// and a finish stage that applies sector offsets and the grey/black cases.
// ----------------------------------------------------------------------------
module rhc_rgb_path
   import rhc_pkg::*;
(
   input  logic    clock,
   input  req_type req,
   output rsp_type result
);

   typedef struct packed {
      cmp_type      red;
      cmp_type      green;
      cmp_type      blue;
      cmp_type      mx;
      cmp_type      d;
      cmp_type      mag;
      hue_case_type hcase;
      logic         neg;
   } front_type;

   front_type front_in, front_ff;
   front_type side_ff [DIV_STAGES];
   front_type last;
   cmp_type   mn;

   logic [HUE_QBITS-1:0]  hue_q;
   cmp_type               sat_q;
   logic [2*CMP_BITS-1:0] sat_num;
   hue_type               hue_base;
   hue_type               hue_sum;
   rsp_type               result_in, result_ff;

   always_comb begin
      front_in       = '0;
      front_in.red   = req.red_in;
      front_in.green = req.green_in;
      front_in.blue  = req.blue_in;
      if (req.red_in >= req.green_in) begin
         front_in.mx = (req.red_in >= req.blue_in) ? req.red_in : req.blue_in;
      end else begin
         front_in.mx = (req.green_in >= req.blue_in) ? req.green_in : req.blue_in;
      end
      if (req.red_in <= req.green_in) begin
         mn = (req.red_in <= req.blue_in) ? req.red_in : req.blue_in;
      end else begin
         mn = (req.green_in <= req.blue_in) ? req.green_in : req.blue_in;
      end
      front_in.d = front_in.mx - mn;
      if (req.red_in == front_in.mx) begin
         front_in.hcase = (req.green_in >= req.blue_in) ? HUE_RED_UP : HUE_RED_DOWN;
      end else if (req.green_in == front_in.mx) begin
         front_in.hcase = HUE_GREEN;
      end else begin
         front_in.hcase = HUE_BLUE;
      end
      case (front_in.hcase)
         HUE_RED_UP: begin
            front_in.mag = req.green_in - req.blue_in;
            front_in.neg = 1'b0;
         end
         HUE_RED_DOWN: begin
            front_in.mag = req.blue_in - req.green_in;
            front_in.neg = 1'b1;
         end
         HUE_GREEN: begin
            front_in.neg = (req.blue_in < req.red_in);
            front_in.mag = front_in.neg ? req.red_in - req.blue_in
                                        : req.blue_in - req.red_in;
         end
         default: begin
            front_in.neg = (req.red_in < req.green_in);
            front_in.mag = front_in.neg ? req.green_in - req.red_in
                                        : req.red_in - req.green_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      front_ff   <= front_in;
      side_ff[0] <= front_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      result_ff  <= result_in;
   end

   assign sat_num = {front_ff.d, CMP_BITS'(0)} - (2 * CMP_BITS)'(front_ff.d);

   rhc_divider #(
      .NW  (CMP_BITS + FRAC_BITS),
      .DW  (CMP_BITS),
      .QB  (HUE_QBITS),
      .NS  (DIV_STAGES),
      .BPS (DIV_BPS)
   ) u_hue_div (
      .clock    (clock),
      .dividend ({front_ff.mag, FRAC_BITS'(0)}),
      .divisor  (front_ff.d),
      .quotient (hue_q)
   );

   rhc_divider #(
      .NW  (2 * CMP_BITS),
      .DW  (CMP_BITS),
      .QB  (CMP_BITS),
      .NS  (DIV_STAGES),
      .BPS (DIV_BPS)
   ) u_sat_div (
      .clock    (clock),
      .dividend (sat_num),
      .divisor  (front_ff.mx),
      .quotient (sat_q)
   );

   assign last = side_ff[DIV_STAGES-1];

   always_comb begin
      case (last.hcase)
         HUE_RED_UP:   hue_base = '0;
         HUE_RED_DOWN: hue_base = TURN_STEPS;
         HUE_GREEN:    hue_base = GREEN_BASE;
         default:      hue_base = BLUE_BASE;
      endcase
      hue_sum = last.neg ? hue_base - HUE_BITS'(hue_q) : hue_base + HUE_BITS'(hue_q);
      if (hue_sum >= TURN_STEPS) begin
         hue_sum = hue_sum - TURN_STEPS;
      end
      if (last.d == '0) begin
         hue_sum = '0;
      end
      result_in.red_out   = last.red;
      result_in.green_out = last.green;
      result_in.blue_out  = last.blue;
      result_in.hue_out   = hue_sum;
      result_in.sat_out   = (last.mx == '0) ? '0 : sat_q;
      result_in.value_out = last.mx;
   end

   assign result = result_ff;

endmodule

@@ design/rhc_hsv_path.sv @@
// ----------------------------------------------------------------------------
// rhc_hsv_path
// HSV to RGB in four stages: hue wrap and sector products, brightness
// products, reciprocal estimate of the divide by full scale, correction and
// sector select.
// ----------------------------------------------------------------------------
module rhc_hsv_path
   import rhc_pkg::*;
(
   input  logic    clock,
   input  req_type req,
   output rsp_type result
);

   localparam int PW = CMP_BITS + FRAC_BITS;
   localparam int YW = 2 * CMP_BITS;
   localparam logic [PW-1:0] SCALE = PW'(CMP_MAX) << FRAC_BITS;

   function automatic cmp_type est_quot(input logic [YW-1:0] y);
      logic [YW:0] sum;
      sum = (YW + 1)'(y) + (YW + 1)'(y >> CMP_BITS);
      return sum[YW-1:CMP_BITS];
   endfunction

   function automatic cmp_type fix_quot(input logic [YW-1:0] y, input cmp_type qe);
      logic [YW:0] r;
      r = (YW + 1)'(y) - ((YW + 1)'(qe) << CMP_BITS) + (YW + 1)'(qe);
      return (r >= (YW + 1)'(CMP_MAX)) ? qe + 1'b1 : qe;
   endfunction

   hue_type              hue_wrap;
   logic [FRAC_BITS-1:0] frac;
   logic [FRAC_BITS:0]   frac_rest;

   // stage 1
   hue_type    hue1_ff;
   cmp_type    sat1_ff, val1_ff, cms1_ff;
   sector_type sec1_ff;
   logic [PW-1:0] sf1_ff, sg1_ff;

   // stage 2
   hue_type    hue2_ff;
   cmp_type    sat2_ff, val2_ff;
   sector_type sec2_ff;
   logic [YW-1:0] yp2_ff, yq2_ff, yt2_ff;
   logic [PW-1:0] qa_in, ta_in;
   logic [YW+FRAC_BITS-1:0] prod_q_in, prod_t_in;

   // stage 3
   hue_type    hue3_ff;
   cmp_type    sat3_ff, val3_ff;
   sector_type sec3_ff;
   logic [YW-1:0] yp3_ff, yq3_ff, yt3_ff;
   cmp_type    ep3_ff, eq3_ff, et3_ff;

   // stage 4
   cmp_type p_in, q_in, t_in;
   rsp_type result_in, result_ff;

   always_comb begin
      hue_wrap  = (req.hue_in >= TURN_STEPS) ? req.hue_in - TURN_STEPS : req.hue_in;
      frac      = hue_wrap[FRAC_BITS-1:0];
      frac_rest = (FRAC_BITS + 1)'(SECTOR_STEPS) - {1'b0, frac};
      qa_in     = SCALE - sf1_ff;
      ta_in     = SCALE - sg1_ff;
      prod_q_in = (YW + FRAC_BITS)'(val1_ff) * (YW + FRAC_BITS)'(qa_in);
      prod_t_in = (YW + FRAC_BITS)'(val1_ff) * (YW + FRAC_BITS)'(ta_in);
   end

   always_ff @(posedge clock) begin
      hue1_ff <= hue_wrap;
      sat1_ff <= req.sat_in;
      val1_ff <= req.value_in;
      cms1_ff <= CMP_MAX - req.sat_in;
      sec1_ff <= sector_type'(hue_wrap[HUE_BITS-1:FRAC_BITS]);
      sf1_ff  <= PW'(req.sat_in) * PW'(frac);
      sg1_ff  <= PW'(req.sat_in) * PW'(frac_rest);

      hue2_ff <= hue1_ff;
      sat2_ff <= sat1_ff;
      val2_ff <= val1_ff;
      sec2_ff <= sec1_ff;
      yp2_ff  <= YW'(val1_ff) * YW'(cms1_ff);
      yq2_ff  <= prod_q_in[YW+FRAC_BITS-1:FRAC_BITS];
      yt2_ff  <= prod_t_in[YW+FRAC_BITS-1:FRAC_BITS];

      hue3_ff <= hue2_ff;
      sat3_ff <= sat2_ff;
      val3_ff <= val2_ff;
      sec3_ff <= sec2_ff;
      yp3_ff  <= yp2_ff;
      yq3_ff  <= yq2_ff;
      yt3_ff  <= yt2_ff;
      ep3_ff  <= est_quot(yp2_ff);
      eq3_ff  <= est_quot(yq2_ff);
      et3_ff  <= est_quot(yt2_ff);

      result_ff <= result_in;
   end

   always_comb begin
      p_in = fix_quot(yp3_ff, ep3_ff);
      q_in = fix_quot(yq3_ff, eq3_ff);
      t_in = fix_quot(yt3_ff, et3_ff);
      result_in.hue_out   = hue3_ff;
      result_in.sat_out   = sat3_ff;
      result_in.value_out = val3_ff;
      case (sec3_ff)
         SEC_RED: begin
            result_in.red_out   = val3_ff;
            result_in.green_out = t_in;
            result_in.blue_out  = p_in;
         end
         SEC_YELLOW: begin
            result_in.red_out   = q_in;
            result_in.green_out = val3_ff;
            result_in.blue_out  = p_in;
         end
         SEC_GREEN: begin
            result_in.red_out   = p_in;
            result_in.green_out = val3_ff;
            result_in.blue_out  = t_in;
         end
         SEC_CYAN: begin
            result_in.red_out   = p_in;
            result_in.green_out = q_in;
            result_in.blue_out  = val3_ff;
         end
         SEC_BLUE: begin
            result_in.red_out   = t_in;
            result_in.green_out = p_in;
            result_in.blue_out  = val3_ff;
         end
         default: begin
            result_in.red_out   = val3_ff;
            result_in.green_out = p_in;
            result_in.blue_out  = q_in;
         end
      endcase
   end

   assign result = result_ff;

endmodule

@@ design/rgb_hsv_color_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter
// Converts one pixel per transaction between RGB and HSV.
//
// Request channel: raise start with req_data; the transaction is taken at
// every rising edge where start is high and busy is low. busy stays low, so
// a new pixel may be issued on every clock. req_data.kind picks the
// direction; the unused triple is ignored.
// Response channel: rsp_valid strobes for one cycle with rsp_data, in
// request order, once the request has passed the valid pipeline and the
// output register. The given triple is echoed, hue wrapped once.
// Throughput is one pixel per clock; the latency is set by the pipelined
// hue/saturation dividers, two quotient bits per stage.
// Reset clears the valid pipeline only; transactions in flight are dropped.
// There is no back-pressure: the receiver must take every strobe.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter
   import rhc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic     accept;
   logic     vld_ff  [PIPE_DEPTH];
   kind_type kind_ff [PIPE_DEPTH];
   rsp_type  hsv_dly_ff [HSV_DELAY];
   rsp_type  rgb_res, hsv_res;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_in, rsp_data_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   rhc_rgb_path u_rgb_path (
      .clock  (clock),
      .req    (req_data),
      .result (rgb_res)
   );

   rhc_hsv_path u_hsv_path (
      .clock  (clock),
      .req    (req_data),
      .result (hsv_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff[0] <= req_data.kind;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         kind_ff[i] <= kind_ff[i-1];
      end
      hsv_dly_ff[0] <= hsv_res;
      for (int i = 1; i < HSV_DELAY; i++) begin
         hsv_dly_ff[i] <= hsv_dly_ff[i-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data_in = (kind_ff[PIPE_DEPTH-1] == KIND_HSV_TO_RGB) ?
                        hsv_dly_ff[HSV_DELAY-1] : rgb_res;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   localparam int RSP_LAG = PIPE_DEPTH + 1;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LAG rsp_valid)
      else $error("accepted transaction produced no response");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LAG))
      else $error("response without a matching transaction");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue_out < TURN_STEPS))
      else $error("hue out of range");

   a_hsv_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(kind_ff[PIPE_DEPTH-1]) == KIND_HSV_TO_RGB) |->
      (rsp_data.red_out == rsp_data.value_out ||
       rsp_data.green_out == rsp_data.value_out ||
       rsp_data.blue_out == rsp_data.value_out))
      else $error("no rgb component equals value");

   a_rgb_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(kind_ff[PIPE_DEPTH-1]) == KIND_RGB_TO_HSV) |->
      (rsp_data.value_out >= rsp_data.red_out &&
       rsp_data.value_out >= rsp_data.green_out &&
       rsp_data.value_out >= rsp_data.blue_out &&
       (rsp_data.value_out != '0 || rsp_data.sat_out == '0)))
      else $error("value is not the rgb maximum");
`endif

endmodule

@@ tb/rhc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_checker
// Watches the request and response channels of the RGB/HSV color converter.
// Each accepted transaction is converted by an independent integer model, and
// the expected pixel is queued. Each response strobe is compared field by
// field against the oldest queued pixel. Mismatches are counted and handed to
// the testbench top together with the number of pixels still in flight.
// ----------------------------------------------------------------------------
module rhc_checker
   import rhc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pixels_in_flight,
   output int      results_checked
);

   localparam int FULL_SCALE = 255;
   localparam int SECTOR     = 256;
   localparam int HUE_TURN   = 6 * SECTOR;

   rsp_type expected_pixels[$];
   rsp_type want;

   function automatic rsp_type convert_pixel(input req_type px);
      rsp_type    res;
      int         r, g, b, mx, mn, d, hh, h, s, v, f, p, q, t, scale;
      sector_type sector;
      if (px.kind == KIND_RGB_TO_HSV) begin
         r  = px.red_in;
         g  = px.green_in;
         b  = px.blue_in;
         mx = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         mn = r;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d  = mx - mn;
         hh = 0;
         if (d != 0) begin
            if (r == mx && g >= b)
               hh = (SECTOR * (g - b)) / d;
            else if (r == mx)
               hh = HUE_TURN - (SECTOR * (b - g)) / d;
            else if (g == mx)
               hh = 2 * SECTOR + (SECTOR * (b - r)) / d;
            else
               hh = 4 * SECTOR + (SECTOR * (r - g)) / d;
            if (hh >= HUE_TURN) hh -= HUE_TURN;
            if (hh < 0) hh += HUE_TURN;
         end
         s = (mx == 0) ? 0 : (FULL_SCALE * d) / mx;
         res.red_out   = cmp_type'(r);
         res.green_out = cmp_type'(g);
         res.blue_out  = cmp_type'(b);
         res.hue_out   = hue_type'(hh);
         res.sat_out   = cmp_type'(s);
         res.value_out = cmp_type'(mx);
      end else begin
         h = px.hue_in;
         if (h >= HUE_TURN) h -= HUE_TURN;
         s      = px.sat_in;
         v      = px.value_in;
         sector = sector_type'(3'(h / SECTOR));
         f      = h % SECTOR;
         scale  = FULL_SCALE * SECTOR;
         p      = (v * (FULL_SCALE - s)) / FULL_SCALE;
         q      = (v * (scale - s * f)) / scale;
         t      = (v * (scale - s * (SECTOR - f))) / scale;
         case (sector)
            SEC_RED: begin
               r = v; g = t; b = p;
            end
            SEC_YELLOW: begin
               r = q; g = v; b = p;
            end
            SEC_GREEN: begin
               r = p; g = v; b = t;
            end
            SEC_CYAN: begin
               r = p; g = q; b = v;
            end
            SEC_BLUE: begin
               r = t; g = p; b = v;
            end
            default: begin
               r = v; g = p; b = q;
            end
         endcase
         res.red_out   = cmp_type'(r);
         res.green_out = cmp_type'(g);
         res.blue_out  = cmp_type'(b);
         res.hue_out   = hue_type'(h);
         res.sat_out   = cmp_type'(s);
         res.value_out = cmp_type'(v);
      end
      return res;
   endfunction

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string field, input int got, input int exp_val);
      if (got != exp_val)
         report($sformatf("%s is %0d, expected %0d", field, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            expected_pixels.push_back(convert_pixel(req_data));
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               report("response strobe with no transaction outstanding");
            end else begin
               want = expected_pixels.pop_front();
               compare_field("red_out",   rsp_data.red_out,   want.red_out);
               compare_field("green_out", rsp_data.green_out, want.green_out);
               compare_field("blue_out",  rsp_data.blue_out,  want.blue_out);
               compare_field("hue_out",   rsp_data.hue_out,   want.hue_out);
               compare_field("sat_out",   rsp_data.sat_out,   want.sat_out);
               compare_field("value_out", rsp_data.value_out, want.value_out);
               results_checked++;
            end
         end
      end
      pixels_in_flight <= expected_pixels.size();
   end

endmodule

@@ tb/tb_rgb_hsv_color_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_hsv_color_converter
// Drives directed corner pixels and then random pixels in both directions
// into the color converter with random and burst gaps between transactions.
// The checker beside the block predicts and compares every response; this
// top makes the stimulus, enforces a cycle limit and prints the verdict.
// ----------------------------------------------------------------------------
module tb_rgb_hsv_color_converter;
   import rhc_pkg::*;

   localparam int RANDOM_PIXELS = 1900;
   localparam int CYCLE_LIMIT   = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatch_count;
   int pixels_in_flight;
   int results_checked;
   int cycle_count = 0;
   int rgb_count   = 0;
   int hsv_count   = 0;
   int max_gap     = 14;

   rgb_hsv_color_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   rhc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type noise_pixel();
      req_type px;
      px.kind     = kind_type'($urandom_range(0, 1));
      px.red_in   = cmp_type'($urandom_range(0, 255));
      px.green_in = cmp_type'($urandom_range(0, 255));
      px.blue_in  = cmp_type'($urandom_range(0, 255));
      px.hue_in   = hue_type'($urandom_range(0, 2047));
      px.sat_in   = cmp_type'($urandom_range(0, 255));
      px.value_in = cmp_type'($urandom_range(0, 255));
      return px;
   endfunction

   function automatic req_type rgb_pixel(input int r, input int g, input int b);
      req_type px;
      px          = noise_pixel();
      px.kind     = KIND_RGB_TO_HSV;
      px.red_in   = cmp_type'(r);
      px.green_in = cmp_type'(g);
      px.blue_in  = cmp_type'(b);
      return px;
   endfunction

   function automatic req_type hsv_pixel(input int h, input int s, input int v);
      req_type px;
      px          = noise_pixel();
      px.kind     = KIND_HSV_TO_RGB;
      px.hue_in   = hue_type'(h);
      px.sat_in   = cmp_type'(s);
      px.value_in = cmp_type'(v);
      return px;
   endfunction

   function automatic int edge_component();
      return ($urandom_range(0, 1) == 0) ? 0 : 255;
   endfunction

   task automatic issue_pixel(input req_type px);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      if (px.kind == KIND_RGB_TO_HSV) rgb_count++;
      else hsv_count++;
   endtask

   initial begin
      req_type px;
      int      c;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_pixel(rgb_pixel(0, 0, 0));
      issue_pixel(rgb_pixel(255, 255, 255));
      issue_pixel(rgb_pixel(128, 128, 128));
      issue_pixel(rgb_pixel(255, 0, 0));
      issue_pixel(rgb_pixel(0, 255, 0));
      issue_pixel(rgb_pixel(0, 0, 255));
      issue_pixel(rgb_pixel(255, 255, 0));
      issue_pixel(rgb_pixel(0, 255, 255));
      issue_pixel(rgb_pixel(255, 0, 255));
      issue_pixel(rgb_pixel(255, 0, 1));
      issue_pixel(rgb_pixel(200, 50, 100));
      issue_pixel(rgb_pixel(10, 200, 255));
      issue_pixel(rgb_pixel(1, 0, 0));
      issue_pixel(hsv_pixel(0, 255, 255));
      issue_pixel(hsv_pixel(256, 255, 255));
      issue_pixel(hsv_pixel(600, 128, 200));
      issue_pixel(hsv_pixel(800, 255, 255));
      issue_pixel(hsv_pixel(1100, 77, 255));
      issue_pixel(hsv_pixel(1400, 255, 180));
      issue_pixel(hsv_pixel(1535, 255, 255));
      issue_pixel(hsv_pixel(1536, 255, 255));
      issue_pixel(hsv_pixel(2047, 255, 255));
      issue_pixel(hsv_pixel(1000, 0, 255));
      issue_pixel(hsv_pixel(500, 255, 0));

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % 100 == 0)
            max_gap = ($urandom_range(0, 2) == 0) ? 0 : 14;
         if (i == RANDOM_PIXELS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (pixels_in_flight != 0);
         end
         px = noise_pixel();
         case ($urandom_range(0, 7))
            0: begin
               c = $urandom_range(0, 255);
               px = rgb_pixel(c, c, c);
            end
            1: px = rgb_pixel(edge_component(), edge_component(), edge_component());
            2: px = hsv_pixel($urandom_range(1536, 2047), px.sat_in, px.value_in);
            3: px = hsv_pixel(px.hue_in, edge_component(), edge_component());
            default: ;
         endcase
         issue_pixel(px);
      end
      start <= 1'b0;

      do @(posedge clock); while (pixels_in_flight != 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      $display("Summary: %0d RGB-to-HSV and %0d HSV-to-RGB transactions, %0d results checked",
               rgb_count, hsv_count, results_checked);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
